// ----- sv/l1wcd_pkg.sv -----
// Shared widths and constants for the L1 worst-case distribution block.
// No dependencies; the interfaces, the MAC unit and the top level use this package.
package l1wcd_pkg;
    localparam int ZW     = 32;
    localparam int PW     = 17;
    localparam int BW     = 18;
    localparam int OBJW   = 48;
    localparam int IDXW   = 5;
    localparam int ACCW   = 56;
    localparam int PRODW  = ZW + PW + 1;
    localparam logic [PW-1:0] ONE_Q16 = 17'd65536;

    typedef logic signed [ZW-1:0]   z_t;
    typedef logic [PW-1:0]          prob_t;
    typedef logic [BW-1:0]          budget_t;
    typedef logic signed [OBJW-1:0] obj_t;
endpackage

// ----- sv/l1wcd_ifs.sv -----
// Handshake channels of the L1 worst-case distribution block.
// Depends on l1wcd_pkg for the payload widths.
interface l1wcd_cfg_if;
    logic                    valid;
    logic                    ready;
    logic [l1wcd_pkg::BW-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface l1wcd_in_if;
    logic                      valid;
    logic                      ready;
    logic signed [l1wcd_pkg::ZW-1:0] z_value;
    logic [l1wcd_pkg::PW-1:0]  q_value;
    logic                      last_in;
    modport source (output valid, output z_value, output q_value, output last_in, input ready);
    modport sink (input valid, input z_value, input q_value, input last_in, output ready);
endinterface

interface l1wcd_out_if;
    logic                        valid;
    logic                        ready;
    logic [l1wcd_pkg::IDXW-1:0]  entry_index;
    logic [l1wcd_pkg::PW-1:0]    prob_out;
    logic signed [l1wcd_pkg::OBJW-1:0] objective;
    logic                        exhausted;
    logic                        last_out;
    modport source (output valid, output entry_index, output prob_out, output objective,
                    output exhausted, output last_out, input ready);
    modport sink (input valid, input entry_index, input prob_out, input objective,
                  input exhausted, input last_out, output ready);
endinterface

// ----- sv/l1wcd_ram.sv -----
// Simple dual-port memory: one write port and one registered read port.
// No dependencies.
module l1wcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/l1wcd_mac.sv -----
// Multiply-accumulate unit for the objective sum of prob times z.
// Depends on l1wcd_pkg; floors the Q24.32 sum to Q32.16 and saturates.
module l1wcd_mac (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              in_valid,
    input  l1wcd_pkg::prob_t  prob,
    input  l1wcd_pkg::z_t     value,
    output logic              busy,
    output l1wcd_pkg::obj_t   objective
);
    import l1wcd_pkg::*;

    localparam logic signed [ACCW-1:0] ObjMax = ACCW'({1'b0, {(OBJW-1){1'b1}}});
    localparam logic signed [ACCW-1:0] ObjMin = -ObjMax - ACCW'(1);

    logic signed [PRODW-1:0] prod_reg;
    logic                    prod_vld_reg;
    logic signed [ACCW-1:0]  acc_reg;
    logic signed [ACCW-1:0]  floored;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= in_valid;
            if (clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + ACCW'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PRODW'($signed({1'b0, prob}) * value);
    end

    always_comb
    begin
        floored = acc_reg >>> 16;
        if (floored > ObjMax)
        begin
            objective = {1'b0, {(OBJW-1){1'b1}}};
        end
        else if (floored < ObjMin)
        begin
            objective = {1'b1, {(OBJW-1){1'b0}}};
        end
        else
        begin
            objective = OBJW'(floored);
        end
    end

    assign busy = prod_vld_reg;
endmodule

// ----- sv/l1_worst_case_distribution.sv -----
// Top level of the L1 worst-case distribution block: sequencer and memories.
// Depends on l1wcd_pkg, l1wcd_ifs, l1wcd_ram and l1wcd_mac.
//
//  channel  direction  payload
//  cfg      in         data (L1 budget, Q2.16)
//  sample   in         z_value, q_value, last_in
//  result   out        entry_index, prob_out, objective, exhausted, last_out
//
// Loading accepts one item per cycle. Ranking compares each entry with all n entries
// of the value memory; the removal walk steps through WALK_RD, WALK_K and WALK_UPD
// per visited entry, the objective pass runs OBJ_RUN over all entries and then
// OBJ_DRAIN, and each result passes OUT_RD and OUT_PUT. Reset clears the sequencer
// and the budget; memories are not cleared. A result stalled at the output register
// holds the sequencer until taken. The budget channel is only ready while loading.
module l1_worst_case_distribution #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    l1wcd_cfg_if.sink    cfg,
    l1wcd_in_if.sink     sample,
    l1wcd_out_if.source  result
);
    import l1wcd_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] CntMax = CW'(MAX_ENTRIES);
    localparam logic [CW-1:0] CntOne = CW'(1);

    typedef enum logic [3:0] {
        LOAD, RANK_RDI, RANK_LDI, RANK_CMP, MIN_RD, MIN_K, MIN_UPD,
        WALK_RD, WALK_K, WALK_UPD, OBJ_RUN, OBJ_DRAIN, OUT_RD, OUT_PUT
    } state_t;

    state_t        state_reg;
    budget_t       budget_reg;
    logic [CW-1:0] cnt_reg, n_reg, i_reg, j_reg, rank_reg, rem_reg;
    logic [IW-1:0] k_reg;
    prob_t         eps_reg;
    z_t            zi_reg;
    logic          v1_reg, exh_reg, mac_clear_reg;
    logic          out_valid_reg, out_last_reg, out_exh_reg;
    logic [IDXW-1:0] out_idx_reg;
    prob_t         out_prob_reg;
    obj_t          out_obj_reg;

    logic          v_we, p_we, o_we;
    logic [IW-1:0] v_waddr, p_waddr, o_waddr, v_raddr, p_raddr, o_raddr;
    z_t            v_wdata, v_rdata;
    prob_t         p_wdata, p_rdata;
    logic [IW-1:0] o_wdata, o_rdata;

    logic          accept, out_take, before_i, load_end;
    logic [CW-1:0] rank_next;
    prob_t         half, room, eps_new, diff;
    logic          mac_busy;
    obj_t          mac_obj;

    assign accept   = sample.valid && sample.ready;
    assign out_take = out_valid_reg && result.ready;
    assign sample.ready = (state_reg == LOAD);
    assign cfg.ready = (state_reg == LOAD);
    assign load_end = sample.last_in || (cnt_reg + CntOne == CntMax);

    assign before_i  = (v_rdata < zi_reg) || ((v_rdata == zi_reg) && (j_reg < i_reg));
    assign rank_next = rank_reg + CW'(before_i);
    assign half      = budget_reg[BW-1:1];
    assign room      = (p_rdata >= ONE_Q16) ? '0 : ONE_Q16 - p_rdata;
    assign eps_new   = (half < room) ? half : room;
    assign diff      = (eps_reg < p_rdata) ? eps_reg : p_rdata;

    always_comb
    begin
        v_we    = accept;
        v_waddr = cnt_reg[IW-1:0];
        v_wdata = sample.z_value;
        p_we    = 1'b0;
        p_waddr = cnt_reg[IW-1:0];
        p_wdata = sample.q_value;
        o_we    = 1'b0;
        o_waddr = rank_next[IW-1:0];
        o_wdata = i_reg[IW-1:0];
        v_raddr = i_reg[IW-1:0];
        p_raddr = i_reg[IW-1:0];
        o_raddr = '0;
        unique case (state_reg)
            LOAD:
            begin
                p_we = accept;
            end
            RANK_LDI:
            begin
                v_raddr = '0;
            end
            RANK_CMP:
            begin
                v_raddr = IW'(j_reg + CntOne);
                o_we    = (j_reg == n_reg - CntOne);
            end
            MIN_K, WALK_K:
            begin
                p_raddr = o_rdata;
            end
            MIN_UPD:
            begin
                p_raddr = k_reg;
                p_we    = 1'b1;
                p_waddr = k_reg;
                p_wdata = p_rdata + eps_new;
            end
            WALK_RD:
            begin
                o_raddr = IW'(rem_reg - CntOne);
            end
            WALK_UPD:
            begin
                p_raddr = k_reg;
                p_we    = 1'b1;
                p_waddr = k_reg;
                p_wdata = p_rdata - diff;
            end
            default:
            begin
            end
        endcase
    end

    l1wcd_ram #(.WIDTH(ZW), .DEPTH(MAX_ENTRIES), .AW(IW)) u_value_ram (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    l1wcd_ram #(.WIDTH(PW), .DEPTH(MAX_ENTRIES), .AW(IW)) u_prob_ram (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    l1wcd_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES), .AW(IW)) u_order_ram (
        .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr(o_raddr), .rdata(o_rdata)
    );

    l1wcd_mac u_mac (
        .clk(clk), .rst_n(rst_n), .clear(mac_clear_reg), .in_valid(v1_reg),
        .prob(p_rdata), .value(v_rdata), .busy(mac_busy), .objective(mac_obj)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= LOAD;
            budget_reg    <= '0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            rank_reg      <= '0;
            rem_reg       <= '0;
            k_reg         <= '0;
            eps_reg       <= '0;
            zi_reg        <= '0;
            v1_reg        <= 1'b0;
            exh_reg       <= 1'b0;
            mac_clear_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_exh_reg   <= 1'b0;
            out_idx_reg   <= '0;
            out_prob_reg  <= '0;
            out_obj_reg   <= '0;
        end
        else
        begin
            mac_clear_reg <= 1'b0;
            v1_reg        <= 1'b0;
            if (cfg.valid && cfg.ready)
            begin
                budget_reg <= cfg.data;
            end
            if (out_take && state_reg != OUT_PUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                LOAD:
                begin
                    if (accept)
                    begin
                        cnt_reg <= cnt_reg + CntOne;
                        if (load_end)
                        begin
                            n_reg     <= cnt_reg + CntOne;
                            i_reg     <= '0;
                            state_reg <= RANK_RDI;
                        end
                    end
                end
                RANK_RDI:
                begin
                    state_reg <= RANK_LDI;
                end
                RANK_LDI:
                begin
                    zi_reg    <= v_rdata;
                    j_reg     <= '0;
                    rank_reg  <= '0;
                    state_reg <= RANK_CMP;
                end
                RANK_CMP:
                begin
                    rank_reg <= rank_next;
                    j_reg    <= j_reg + CntOne;
                    if (j_reg == n_reg - CntOne)
                    begin
                        i_reg <= i_reg + CntOne;
                        state_reg <= (i_reg == n_reg - CntOne) ? MIN_RD : RANK_RDI;
                    end
                end
                MIN_RD:
                begin
                    state_reg <= MIN_K;
                end
                MIN_K:
                begin
                    k_reg     <= o_rdata;
                    state_reg <= MIN_UPD;
                end
                MIN_UPD:
                begin
                    eps_reg   <= eps_new;
                    rem_reg   <= n_reg;
                    state_reg <= WALK_RD;
                end
                WALK_RD:
                begin
                    if (eps_reg == '0 || rem_reg == '0)
                    begin
                        exh_reg       <= (eps_reg != '0);
                        mac_clear_reg <= 1'b1;
                        i_reg         <= '0;
                        state_reg     <= OBJ_RUN;
                    end
                    else
                    begin
                        state_reg <= WALK_K;
                    end
                end
                WALK_K:
                begin
                    k_reg     <= o_rdata;
                    state_reg <= WALK_UPD;
                end
                WALK_UPD:
                begin
                    eps_reg   <= eps_reg - diff;
                    rem_reg   <= rem_reg - CntOne;
                    state_reg <= WALK_RD;
                end
                OBJ_RUN:
                begin
                    v1_reg <= 1'b1;
                    i_reg  <= i_reg + CntOne;
                    if (i_reg == n_reg - CntOne)
                    begin
                        state_reg <= OBJ_DRAIN;
                    end
                end
                OBJ_DRAIN:
                begin
                    if (!v1_reg && !mac_busy)
                    begin
                        i_reg     <= '0;
                        state_reg <= OUT_RD;
                    end
                end
                OUT_RD:
                begin
                    state_reg <= OUT_PUT;
                end
                OUT_PUT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_idx_reg   <= IDXW'(i_reg);
                        out_prob_reg  <= p_rdata;
                        out_exh_reg   <= exh_reg;
                        out_last_reg  <= (i_reg == n_reg - CntOne);
                        out_obj_reg   <= (i_reg == n_reg - CntOne) ? mac_obj : '0;
                        i_reg         <= i_reg + CntOne;
                        if (i_reg == n_reg - CntOne)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= LOAD;
                        end
                        else
                        begin
                            state_reg <= OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= LOAD;
                end
            endcase
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.entry_index = out_idx_reg;
    assign result.prob_out    = out_prob_reg;
    assign result.objective   = out_obj_reg;
    assign result.exhausted   = out_exh_reg;
    assign result.last_out    = out_last_reg;

`ifndef SYNTHESIS
    a_eps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        eps_reg <= ONE_Q16) else $error("Mass to remove exceeds one.");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == WALK_RD |-> rem_reg <= n_reg)
        else $error("Walk counter beyond vector length.");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntMax) else $error("Load count beyond store depth.");
    a_walk_eps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == WALK_UPD |=> eps_reg <= $past(eps_reg))
        else $error("Removal walk increased the remaining mass.");
`endif
endmodule
